// ===== rtl/core/nps_pkg.sv =====
package nps_pkg;

  localparam int CAPACITY   = 1024;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int COORD_W    = 16;
  localparam int SQ_W       = 27;
  localparam int ROOT_W     = 22;
  localparam int SRC_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 3;

  localparam logic [SQ_W-1:0]   LIMIT_SQ   = 27'd100000000;
  localparam logic [ROOT_W-1:0] LIMIT_ROOT = 22'd2560000;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // one stage of the digit-by-digit square root
  typedef struct packed {
    logic              valid;
    logic [SRC_W-1:0]  src;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_stage_t;

  // running best match of a scan, position is 1-based
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] pos;
    logic [SQ_W-1:0]  sq;
  } near_t;

endpackage

// ===== rtl/core/nps_root_cell.sv =====
module nps_root_cell
  import nps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  root_stage_t stg_in,
  output root_stage_t stg_out
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;
  root_stage_t      stg_nxt;
  root_stage_t      stg_r;

  // remainder stays below 2*root+1, so its top two bits are always zero here
  assign rem_sh = {stg_in.rem[REM_W-3:0], stg_in.src[SRC_W-1 -: 2]};
  assign trial  = REM_W'({stg_in.root, 2'b01});
  assign take   = (rem_sh >= trial);

  always_comb begin
    stg_nxt.valid = stg_in.valid;
    stg_nxt.src   = {stg_in.src[SRC_W-3:0], 2'b00};
    stg_nxt.rem   = take ? (rem_sh - trial) : rem_sh;
    stg_nxt.root  = {stg_in.root[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    stg_r.src  <= stg_nxt.src;
    stg_r.rem  <= stg_nxt.rem;
    stg_r.root <= stg_nxt.root;
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else begin
      stg_r.valid <= stg_nxt.valid;
    end
  end

  assign stg_out = stg_r;

endmodule

// ===== rtl/core/nps_root_chain.sv =====
module nps_root_chain
  import nps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  root_stage_t stg_in,
  output root_stage_t stg_out
);

  root_stage_t stg [0:ROOT_W];

  assign stg[0] = stg_in;

  // one result bit per cell, the value walks down the row one cell per cycle
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    nps_root_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stg_in  (stg[i]),
      .stg_out (stg[i+1])
    );
  end

  assign stg_out = stg[ROOT_W];

endmodule

// ===== rtl/core/nps_dist_unit.sv =====
module nps_dist_unit
  import nps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic                      pt_vld,
  input  logic [IDX_W-1:0]          pt_idx,
  input  logic signed [COORD_W-1:0] pt_x,
  input  logic signed [COORD_W-1:0] pt_y,
  input  logic signed [COORD_W-1:0] q_x,
  input  logic signed [COORD_W-1:0] q_y,
  output near_t                     near,
  output logic                      busy
);

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic [COORD_W-1:0]      ax;
  logic [COORD_W-1:0]      ay;

  logic                    a_vld_r;
  logic [IDX_W-1:0]        a_idx_r;
  logic [COORD_W-1:0]      a_ax_r;
  logic [COORD_W-1:0]      a_ay_r;

  logic                    b_vld_r;
  logic [IDX_W-1:0]        b_idx_r;
  logic [2*COORD_W-1:0]    b_sx_r;
  logic [2*COORD_W-1:0]    b_sy_r;

  logic                    c_vld_r;
  logic [IDX_W-1:0]        c_idx_r;
  logic [2*COORD_W:0]      c_sum_r;

  logic                    found_r;
  logic [CNT_W-1:0]        pos_r;
  logic [SQ_W-1:0]         best_r;

  assign dx = {q_x[COORD_W-1], q_x} - {pt_x[COORD_W-1], pt_x};
  assign dy = {q_y[COORD_W-1], q_y} - {pt_y[COORD_W-1], pt_y};
  assign ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  always_ff @(posedge clk) begin
    a_idx_r <= pt_idx;
    a_ax_r  <= ax;
    a_ay_r  <= ay;
    b_idx_r <= a_idx_r;
    b_sx_r  <= a_ax_r * a_ax_r;
    b_sy_r  <= a_ay_r * a_ay_r;
    c_idx_r <= b_idx_r;
    c_sum_r <= {1'b0, b_sx_r} + {1'b0, b_sy_r};
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= pt_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  // strict compare keeps the earliest point on a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      pos_r   <= CNT_W'(1);
      best_r  <= LIMIT_SQ;
    end else if (clr) begin
      found_r <= 1'b0;
      pos_r   <= CNT_W'(1);
      best_r  <= LIMIT_SQ;
    end else if (c_vld_r && (c_sum_r < (2*COORD_W+1)'(best_r))) begin
      found_r <= 1'b1;
      pos_r   <= CNT_W'(c_idx_r) + CNT_W'(1);
      best_r  <= c_sum_r[SQ_W-1:0];
    end
  end

  assign near.found = found_r;
  assign near.pos   = pos_r;
  assign near.sq    = best_r;
  assign busy       = a_vld_r | b_vld_r | c_vld_r;

endmodule

// ===== rtl/core/nearest_point_search_table.sv =====
// Add, remove and unused opcodes go straight to the hold state; the result is loaded into the
// output register from there once the output is free. A query first scans every stored point:
// a distance pipe fed one point per cycle, then a 22-cell square root row, then the hold state.
// Next request is taken the cycle after the result is loaded, not while one is in progress;
// one request is taken while a result waits, then the block holds.
// Reset clears the point count and all control state; the point store is not cleared.
module nearest_point_search_table
  import nps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // coord_x[15:0], coord_y[31:16]
  input  logic [IN_USER_W-1:0]  in_tuser,   // opcode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // entry_count[10:0], nearest_position[21:11],
                                            // squared_distance[48:22], root_distance[70:49]
  output logic [OUT_USER_W-1:0] out_tuser   // status[1:0], found[2]
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ROOT,
    S_HOLD
  } state_t;

  state_t                     state_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           rd_ptr_r;
  logic                       rd_vld_r;
  logic [IDX_W-1:0]           rd_idx_r;
  logic [IN_DATA_W-1:0]       rd_data_r;
  logic signed [COORD_W-1:0]  q_x_r;
  logic signed [COORD_W-1:0]  q_y_r;

  logic [1:0]                 res_status_r;
  logic [CNT_W-1:0]           res_count_r;
  logic                       res_found_r;
  logic [CNT_W-1:0]           res_pos_r;
  logic [SQ_W-1:0]            res_sq_r;
  logic [ROOT_W-1:0]          res_root_r;

  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r;
  logic [OUT_USER_W-1:0]      out_user_r;

  logic [IN_DATA_W-1:0]       mem [0:CAPACITY-1];

  logic                       accept;
  opcode_t                    op;
  logic                       is_full;
  logic                       wr_en;
  logic                       issue;
  logic                       scan_done;
  logic                       load_out;
  logic                       dist_busy;
  near_t                      near;
  root_stage_t                root_in;
  root_stage_t                root_out;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign op        = opcode_t'(in_tuser);
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign wr_en     = accept && (op == OP_ADD) && !is_full;
  assign issue     = (state_r == S_SCAN) && (rd_ptr_r < count_r);
  assign scan_done = (state_r == S_SCAN) && !issue && !rd_vld_r && !dist_busy;
  assign load_out  = (state_r == S_HOLD) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= in_tdata;
    end
    rd_data_r <= mem[rd_ptr_r[IDX_W-1:0]];
    rd_idx_r  <= rd_ptr_r[IDX_W-1:0];
  end

  nps_dist_unit u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (accept && (op == OP_QUERY)),
    .pt_vld (rd_vld_r),
    .pt_idx (rd_idx_r),
    .pt_x   (rd_data_r[COORD_W-1:0]),
    .pt_y   (rd_data_r[2*COORD_W-1:COORD_W]),
    .q_x    (q_x_r),
    .q_y    (q_y_r),
    .near   (near),
    .busy   (dist_busy)
  );

  // root of d2 with 8 fraction bits: isqrt(d2 << 16)
  always_comb begin
    root_in.valid = scan_done;
    root_in.src   = {1'b0, near.sq, 16'b0};
    root_in.rem   = '0;
    root_in.root  = '0;
  end

  nps_root_chain u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .stg_in  (root_in),
    .stg_out (root_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      rd_ptr_r     <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (issue) begin
        rd_ptr_r <= rd_ptr_r + CNT_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_found_r  <= 1'b0;
            res_pos_r    <= CNT_W'(1);
            res_sq_r     <= LIMIT_SQ;
            res_root_r   <= LIMIT_ROOT;
            case (op)
              OP_ADD: begin
                state_r <= S_HOLD;
                if (is_full) begin
                  res_status_r <= ST_FULL;
                  res_count_r  <= count_r;
                end else begin
                  res_status_r <= ST_OK;
                  count_r      <= count_r + CNT_W'(1);
                  res_count_r  <= count_r + CNT_W'(1);
                end
              end
              OP_REMOVE: begin
                state_r <= S_HOLD;
                if (count_r == '0) begin
                  res_status_r <= ST_EMPTY;
                  res_count_r  <= count_r;
                end else begin
                  res_status_r <= ST_OK;
                  count_r      <= count_r - CNT_W'(1);
                  res_count_r  <= count_r - CNT_W'(1);
                end
              end
              OP_QUERY: begin
                res_status_r <= ST_OK;
                res_count_r  <= count_r;
                q_x_r        <= in_tdata[COORD_W-1:0];
                q_y_r        <= in_tdata[2*COORD_W-1:COORD_W];
                rd_ptr_r     <= '0;
                state_r      <= S_SCAN;
              end
              default: begin
                res_status_r <= ST_OK;
                res_count_r  <= count_r;
                state_r      <= S_HOLD;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            res_found_r <= near.found;
            res_pos_r   <= near.pos;
            res_sq_r    <= near.sq;
            state_r     <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_out.valid) begin
            res_root_r <= root_out.root;
            state_r    <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load_out) begin
            out_data_r  <= {1'b0, res_root_r, res_sq_r, res_pos_r, res_count_r};
            out_user_r  <= {res_found_r, res_status_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("point count above capacity");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!dist_busy && !rd_vld_r))
    else $error("distance pipe busy while idle");

  a_root_in_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    root_out.valid |-> (state_r == S_ROOT))
    else $error("root result outside root wait");

  a_nomatch_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> (out_tdata[48:22] == LIMIT_SQ))
    else $error("no match but distance below limit");

endmodule
